@@ rtl/core/ldu_pkg.sv @@
// Package for the lens distortion block: widths, fixed-point constants, codes,
// sequencer states and the microprogram that drives the shared arithmetic units.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package ldu_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 32;
    localparam int TOL_W   = 28;
    localparam int IDX_W   = 3;
    localparam int FRAC    = 28;
    localparam int WORD_W  = 62;
    localparam int MAG_W   = WORD_W - 1;
    localparam int HALF_W  = 31;
    localparam int DIVD_W  = MAG_W + FRAC;

    localparam int MAX_ITERATIONS = 10;
    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    localparam logic signed [WORD_W-1:0] LIM = (62'sd1 <<< 60) - 62'sd1;
    localparam logic signed [WORD_W-1:0] ONE = 62'sd1 <<< FRAC;

    localparam logic [TOL_W-1:0] TOL_RESET = 28'd2684;

    localparam logic [IDX_W-1:0] CFG_K1  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_K2  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_K3  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_P1  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_P2  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TOL = 3'd5;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        U_ADD,
        U_SUB,
        U_MUL,
        U_DIV,
        U_SPLIT,
        U_FIN,
        U_CONV,
        U_SING,
        U_LOOP
    } uop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_WAIT,
        S_ORD,
        S_OWR
    } seq_state_t;

    typedef logic [5:0] src_t;

    localparam src_t R_EX   = 6'd0;
    localparam src_t R_EY   = 6'd1;
    localparam src_t R_X2   = 6'd2;
    localparam src_t R_Y2   = 6'd3;
    localparam src_t R_R2   = 6'd4;
    localparam src_t R_R4   = 6'd5;
    localparam src_t R_E    = 6'd6;
    localparam src_t R_C    = 6'd7;
    localparam src_t R_RAD  = 6'd8;
    localparam src_t R_T    = 6'd9;
    localparam src_t R_TT   = 6'd10;
    localparam src_t R_AX   = 6'd11;
    localparam src_t R_AY   = 6'd12;
    localparam src_t R_FX   = 6'd13;
    localparam src_t R_FY   = 6'd14;
    localparam src_t R_RX   = 6'd15;
    localparam src_t R_RY   = 6'd16;
    localparam src_t R_TMP  = 6'd17;
    localparam src_t R_TMP2 = 6'd18;
    localparam src_t R_D    = 6'd19;
    localparam src_t R_K2R  = 6'd20;
    localparam src_t R_TX2  = 6'd21;
    localparam src_t R_TY2  = 6'd22;
    localparam src_t R_XD   = 6'd23;
    localparam src_t R_YD   = 6'd24;
    localparam src_t R_J0   = 6'd25;
    localparam src_t R_J1   = 6'd26;
    localparam src_t R_J2   = 6'd27;
    localparam src_t R_J3   = 6'd28;
    localparam src_t R_DET  = 6'd29;
    localparam src_t R_NUM  = 6'd30;

    localparam src_t S_ZERO = 6'd32;
    localparam src_t S_ONE  = 6'd33;
    localparam src_t S_TX   = 6'd34;
    localparam src_t S_TY   = 6'd35;
    localparam src_t S_K1   = 6'd36;
    localparam src_t S_K2   = 6'd37;
    localparam src_t S_K3   = 6'd38;
    localparam src_t S_P1   = 6'd39;
    localparam src_t S_P2   = 6'd40;

    typedef struct packed {
        uop_t op;
        src_t a;
        src_t b;
        src_t dst;
    } instr_t;

    localparam int PC_W = 7;
    localparam int PROG_LEN = 87;
    localparam logic [PC_W-1:0] L_LOOP  = 7'd2;
    localparam logic [PC_W-1:0] L_RESID = 7'd33;

    function automatic instr_t mk(input uop_t op, input src_t a, input src_t b,
                                  input src_t d);
        instr_t r;
        r.op  = op;
        r.a   = a;
        r.b   = b;
        r.dst = d;
        return r;
    endfunction

    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            7'd0:  r = mk(U_ADD, S_TX, S_ZERO, R_EX);
            7'd1:  r = mk(U_ADD, S_TY, S_ZERO, R_EY);
            7'd2:  r = mk(U_MUL, R_EX, R_EX, R_X2);
            7'd3:  r = mk(U_MUL, R_EY, R_EY, R_Y2);
            7'd4:  r = mk(U_ADD, R_X2, R_Y2, R_R2);
            7'd5:  r = mk(U_MUL, R_R2, R_R2, R_R4);
            7'd6:  r = mk(U_MUL, R_R4, R_R2, R_E);
            7'd7:  r = mk(U_MUL, S_K1, R_R2, R_TMP);
            7'd8:  r = mk(U_ADD, S_ONE, R_TMP, R_C);
            7'd9:  r = mk(U_MUL, S_K2, R_R4, R_TMP);
            7'd10: r = mk(U_ADD, R_C, R_TMP, R_C);
            7'd11: r = mk(U_MUL, S_K3, R_E, R_TMP);
            7'd12: r = mk(U_ADD, R_C, R_TMP, R_RAD);
            7'd13: r = mk(U_MUL, R_EX, R_EY, R_T);
            7'd14: r = mk(U_ADD, R_T, R_T, R_TT);
            7'd15: r = mk(U_ADD, R_X2, R_X2, R_AX);
            7'd16: r = mk(U_ADD, R_AX, R_R2, R_AX);
            7'd17: r = mk(U_ADD, R_Y2, R_Y2, R_AY);
            7'd18: r = mk(U_ADD, R_AY, R_R2, R_AY);
            7'd19: r = mk(U_MUL, R_EX, R_RAD, R_TMP);
            7'd20: r = mk(U_MUL, S_P1, R_TT, R_TMP2);
            7'd21: r = mk(U_ADD, R_TMP, R_TMP2, R_TMP);
            7'd22: r = mk(U_MUL, S_P2, R_AX, R_TMP2);
            7'd23: r = mk(U_ADD, R_TMP, R_TMP2, R_FX);
            7'd24: r = mk(U_MUL, R_EY, R_RAD, R_TMP);
            7'd25: r = mk(U_MUL, S_P1, R_AY, R_TMP2);
            7'd26: r = mk(U_ADD, R_TMP, R_TMP2, R_TMP);
            7'd27: r = mk(U_MUL, S_P2, R_TT, R_TMP2);
            7'd28: r = mk(U_ADD, R_TMP, R_TMP2, R_FY);
            7'd29: r = mk(U_SPLIT, S_ZERO, S_ZERO, R_EX);
            7'd30: r = mk(U_ADD, R_FX, S_ZERO, R_EX);
            7'd31: r = mk(U_ADD, R_FY, S_ZERO, R_EY);
            7'd32: r = mk(U_FIN, S_ZERO, S_ZERO, R_EX);
            7'd33: r = mk(U_SUB, S_TX, R_FX, R_RX);
            7'd34: r = mk(U_SUB, S_TY, R_FY, R_RY);
            7'd35: r = mk(U_CONV, R_RX, R_RY, R_EX);
            7'd36: r = mk(U_MUL, S_K2, R_R2, R_K2R);
            7'd37: r = mk(U_ADD, R_K2R, R_K2R, R_TMP);
            7'd38: r = mk(U_ADD, S_K1, R_TMP, R_D);
            7'd39: r = mk(U_MUL, S_K3, R_R4, R_TMP);
            7'd40: r = mk(U_ADD, R_TMP, R_TMP, R_TMP2);
            7'd41: r = mk(U_ADD, R_TMP2, R_TMP, R_TMP2);
            7'd42: r = mk(U_ADD, R_D, R_TMP2, R_D);
            7'd43: r = mk(U_ADD, R_EX, R_EX, R_TX2);
            7'd44: r = mk(U_ADD, R_EY, R_EY, R_TY2);
            7'd45: r = mk(U_MUL, R_EX, R_D, R_XD);
            7'd46: r = mk(U_MUL, R_EY, R_D, R_YD);
            7'd47: r = mk(U_MUL, R_XD, R_TX2, R_TMP);
            7'd48: r = mk(U_ADD, R_RAD, R_TMP, R_J0);
            7'd49: r = mk(U_MUL, S_P1, R_TY2, R_TMP);
            7'd50: r = mk(U_ADD, R_J0, R_TMP, R_J0);
            7'd51: r = mk(U_MUL, S_P2, R_TX2, R_TMP);
            7'd52: r = mk(U_ADD, R_TMP, R_TMP, R_TMP2);
            7'd53: r = mk(U_ADD, R_TMP2, R_TMP, R_TMP2);
            7'd54: r = mk(U_ADD, R_J0, R_TMP2, R_J0);
            7'd55: r = mk(U_MUL, R_XD, R_TY2, R_TMP);
            7'd56: r = mk(U_MUL, S_P1, R_TX2, R_TMP2);
            7'd57: r = mk(U_ADD, R_TMP, R_TMP2, R_J1);
            7'd58: r = mk(U_MUL, S_P2, R_TY2, R_TMP);
            7'd59: r = mk(U_ADD, R_J1, R_TMP, R_J1);
            7'd60: r = mk(U_MUL, R_YD, R_TX2, R_TMP);
            7'd61: r = mk(U_ADD, R_TMP, R_TMP2, R_J2);
            7'd62: r = mk(U_MUL, S_P2, R_TY2, R_TMP2);
            7'd63: r = mk(U_ADD, R_J2, R_TMP2, R_J2);
            7'd64: r = mk(U_MUL, R_YD, R_TY2, R_TMP);
            7'd65: r = mk(U_ADD, R_RAD, R_TMP, R_J3);
            7'd66: r = mk(U_MUL, S_P1, R_TY2, R_TMP);
            7'd67: r = mk(U_ADD, R_TMP, R_TMP, R_TMP2);
            7'd68: r = mk(U_ADD, R_TMP2, R_TMP, R_TMP2);
            7'd69: r = mk(U_ADD, R_J3, R_TMP2, R_J3);
            7'd70: r = mk(U_MUL, S_P2, R_TX2, R_TMP);
            7'd71: r = mk(U_ADD, R_J3, R_TMP, R_J3);
            7'd72: r = mk(U_MUL, R_J0, R_J3, R_TMP);
            7'd73: r = mk(U_MUL, R_J1, R_J2, R_TMP2);
            7'd74: r = mk(U_SUB, R_TMP, R_TMP2, R_DET);
            7'd75: r = mk(U_SING, R_DET, S_ZERO, R_EX);
            7'd76: r = mk(U_MUL, R_J3, R_RX, R_TMP);
            7'd77: r = mk(U_MUL, R_J1, R_RY, R_TMP2);
            7'd78: r = mk(U_SUB, R_TMP, R_TMP2, R_NUM);
            7'd79: r = mk(U_DIV, R_NUM, R_DET, R_TMP);
            7'd80: r = mk(U_ADD, R_EX, R_TMP, R_EX);
            7'd81: r = mk(U_MUL, R_J0, R_RY, R_TMP);
            7'd82: r = mk(U_MUL, R_J2, R_RX, R_TMP2);
            7'd83: r = mk(U_SUB, R_TMP, R_TMP2, R_NUM);
            7'd84: r = mk(U_DIV, R_NUM, R_DET, R_TMP);
            7'd85: r = mk(U_ADD, R_EY, R_TMP, R_EY);
            7'd86: r = mk(U_LOOP, S_ZERO, S_ZERO, R_EX);
            default: r = mk(U_FIN, S_ZERO, S_ZERO, R_EX);
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/ldu_ifs.sv @@
// Valid/ready channel interfaces of the lens distortion block: input point,
// result and configuration write. Depends on ldu_pkg for the field widths.
`timescale 1ns / 1ps

interface ldu_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [ldu_pkg::COORD_W-1:0]  in_x;
    logic signed [ldu_pkg::COORD_W-1:0]  in_y;
    modport source (output valid, output op, output in_x, output in_y, input ready);
    modport sink   (input valid, input op, input in_x, input in_y, output ready);
endinterface

interface ldu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ldu_pkg::COORD_W-1:0]  out_x;
    logic signed [ldu_pkg::COORD_W-1:0]  out_y;
    logic                                converged;
    logic                                singular;
    modport source (output valid, output out_x, output out_y, output converged,
                    output singular, input ready);
    modport sink   (input valid, input out_x, input out_y, input converged,
                    input singular, output ready);
endinterface

interface ldu_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ldu_pkg::IDX_W-1:0]           index;
    logic [ldu_pkg::COEF_W-1:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ldu_mul.sv @@
// Iterative fixed-point multiplier: four 31x31 partial products accumulated
// over successive cycles, then rounded half away from zero and saturated.
// Depends on ldu_pkg.
`timescale 1ns / 1ps

module ldu_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ldu_pkg::word_t      a,
    input  ldu_pkg::word_t      b,
    output logic                done,
    output ldu_pkg::word_t      p
);

    localparam int ACC_W = 2 * ldu_pkg::MAG_W;
    localparam int HI_W  = ldu_pkg::MAG_W - ldu_pkg::HALF_W;
    localparam int RND_W = ACC_W - ldu_pkg::FRAC;

    logic [ldu_pkg::MAG_W-1:0]     ua_reg;
    logic [ldu_pkg::MAG_W-1:0]     ub_reg;
    logic                          neg_reg;
    logic                          busy_reg;
    logic [2:0]                    cnt_reg;
    logic [2*ldu_pkg::HALF_W-1:0]  pp_reg;
    logic [1:0]                    sh_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic                          done_reg;
    ldu_pkg::word_t                p_reg;

    logic [ldu_pkg::WORD_W-1:0]    abs_a;
    logic [ldu_pkg::WORD_W-1:0]    abs_b;
    logic [ldu_pkg::HALF_W-1:0]    a_part;
    logic [ldu_pkg::HALF_W-1:0]    b_part;
    logic [ACC_W-1:0]              pp_shift;
    logic [ACC_W-1:0]              rnd;
    logic [RND_W-1:0]              mag;
    ldu_pkg::word_t                res;

    assign abs_a = a[ldu_pkg::WORD_W-1] ? -a : a;
    assign abs_b = b[ldu_pkg::WORD_W-1] ? -b : b;

    always_comb
    begin
        a_part = cnt_reg[1] ? {1'b0, ua_reg[ldu_pkg::MAG_W-1:ldu_pkg::HALF_W]}
                            : ua_reg[ldu_pkg::HALF_W-1:0];
        b_part = cnt_reg[0] ? {1'b0, ub_reg[ldu_pkg::MAG_W-1:ldu_pkg::HALF_W]}
                            : ub_reg[ldu_pkg::HALF_W-1:0];
        case (sh_reg)
            2'd0:    pp_shift = ACC_W'(pp_reg);
            2'd1:    pp_shift = ACC_W'(pp_reg) << ldu_pkg::HALF_W;
            default: pp_shift = ACC_W'(pp_reg) << (2 * ldu_pkg::HALF_W);
        endcase
        rnd = acc_reg + (ACC_W'(1) << (ldu_pkg::FRAC - 1));
        mag = rnd[ACC_W-1:ldu_pkg::FRAC];
        if (mag > RND_W'(ldu_pkg::LIM))
        begin
            res = ldu_pkg::LIM;
        end
        else
        begin
            res = ldu_pkg::word_t'(mag[ldu_pkg::WORD_W-1:0]);
        end
        if (neg_reg)
        begin
            res = -res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= abs_a[ldu_pkg::MAG_W-1:0];
            ub_reg  <= abs_b[ldu_pkg::MAG_W-1:0];
            neg_reg <= a[ldu_pkg::WORD_W-1] ^ b[ldu_pkg::WORD_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                pp_reg <= a_part * b_part;
                sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_shift;
            end
            if (cnt_reg == 3'd5)
            begin
                p_reg <= res;
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

@@ rtl/core/ldu_div.sv @@
// Bit-serial restoring divider for the Newton step: quotient of n * 2^28 / d
// truncated toward zero and saturated, one quotient bit per cycle.
// Depends on ldu_pkg.
`timescale 1ns / 1ps

module ldu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ldu_pkg::word_t      n,
    input  ldu_pkg::word_t      d,
    output logic                done,
    output ldu_pkg::word_t      q
);

    localparam int CNT_W = $clog2(ldu_pkg::DIVD_W + 1);

    logic [ldu_pkg::DIVD_W-1:0]  dq_reg;
    logic [ldu_pkg::MAG_W-1:0]   rem_reg;
    logic [ldu_pkg::MAG_W-1:0]   ud_reg;
    logic                        neg_reg;
    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        done_reg;
    ldu_pkg::word_t              q_reg;

    logic [ldu_pkg::WORD_W-1:0]  abs_n;
    logic [ldu_pkg::WORD_W-1:0]  abs_d;
    logic [ldu_pkg::MAG_W:0]     trial;
    logic [ldu_pkg::MAG_W:0]     diff;
    logic                        qbit;
    ldu_pkg::word_t              res;

    assign abs_n = n[ldu_pkg::WORD_W-1] ? -n : n;
    assign abs_d = d[ldu_pkg::WORD_W-1] ? -d : d;

    always_comb
    begin
        trial = {rem_reg, dq_reg[ldu_pkg::DIVD_W-1]};
        diff  = trial - {1'b0, ud_reg};
        qbit  = (trial >= {1'b0, ud_reg});
        if (dq_reg > ldu_pkg::DIVD_W'(ldu_pkg::LIM))
        begin
            res = ldu_pkg::LIM;
        end
        else
        begin
            res = ldu_pkg::word_t'(dq_reg[ldu_pkg::WORD_W-1:0]);
        end
        if (neg_reg)
        begin
            res = -res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(ldu_pkg::DIVD_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {abs_n[ldu_pkg::MAG_W-1:0], {ldu_pkg::FRAC{1'b0}}};
            rem_reg <= '0;
            ud_reg  <= abs_d[ldu_pkg::MAG_W-1:0];
            neg_reg <= n[ldu_pkg::WORD_W-1] ^ d[ldu_pkg::WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(ldu_pkg::DIVD_W))
            begin
                q_reg <= res;
            end
            else
            begin
                rem_reg <= qbit ? diff[ldu_pkg::MAG_W-1:0] : trial[ldu_pkg::MAG_W-1:0];
                dq_reg  <= {dq_reg[ldu_pkg::DIVD_W-2:0], qbit};
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

@@ rtl/core/lens_distort_undistort.sv @@
// Lens distortion and Newton undistortion; one point at a time under a microcoded sequencer.
// Distort runs the forward model once; undistort repeats Newton iterations, up to 10,
// each waiting on the iterative multiplier and the bit-serial divider.
// The next point is accepted while a finished result waits in the output register.
// rst_n clears the sequencer, restores coefficients to 0 and tolerance to 2684.
// Depends on ldu_pkg, ldu_ifs, ldu_mul and ldu_div.
`timescale 1ns / 1ps

module lens_distort_undistort (
    input  logic        clk,
    input  logic        rst_n,
    ldu_in_if.sink      in_ch,
    ldu_out_if.source   out_ch,
    ldu_cfg_if.sink     cfg_ch
);

    ldu_pkg::seq_state_t              state_reg;
    ldu_pkg::seq_state_t              state_next;
    logic [ldu_pkg::PC_W-1:0]         pc_reg;
    logic [ldu_pkg::PC_W-1:0]         pc_next;
    logic [ldu_pkg::ITER_W-1:0]       iter_reg;
    logic [ldu_pkg::ITER_W-1:0]       iter_next;
    logic                             conv_reg;
    logic                             conv_next;
    logic                             sing_reg;
    logic                             sing_next;
    logic                             op_reg;
    logic signed [ldu_pkg::COORD_W-1:0] tx_reg;
    logic signed [ldu_pkg::COORD_W-1:0] ty_reg;

    logic signed [ldu_pkg::COEF_W-1:0] k1_reg;
    logic signed [ldu_pkg::COEF_W-1:0] k2_reg;
    logic signed [ldu_pkg::COEF_W-1:0] k3_reg;
    logic signed [ldu_pkg::COEF_W-1:0] p1_reg;
    logic signed [ldu_pkg::COEF_W-1:0] p2_reg;
    logic [ldu_pkg::TOL_W-1:0]         tol_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [ldu_pkg::COORD_W-1:0] out_x_reg;
    logic signed [ldu_pkg::COORD_W-1:0] out_y_reg;
    logic                             out_conv_reg;
    logic                             out_sing_reg;
    logic                             out_load;

    ldu_pkg::word_t                   rf_mem [ldu_pkg::RF_DEPTH];
    ldu_pkg::word_t                   rda_reg;
    ldu_pkg::word_t                   rdb_reg;
    logic [ldu_pkg::RF_AW-1:0]        ra;
    logic [ldu_pkg::RF_AW-1:0]        rb;
    logic                             rf_we;
    ldu_pkg::word_t                   rf_wdata;

    ldu_pkg::instr_t                  instr;
    ldu_pkg::word_t                   opa;
    ldu_pkg::word_t                   opb;
    logic [ldu_pkg::WORD_W-1:0]       mag_a;
    logic [ldu_pkg::WORD_W-1:0]       mag_b;
    logic                             mul_start;
    logic                             mul_done;
    ldu_pkg::word_t                   mul_p;
    logic                             div_start;
    logic                             div_done;
    ldu_pkg::word_t                   div_q;

    function automatic ldu_pkg::word_t coef(input logic signed [ldu_pkg::COEF_W-1:0] k);
        return ldu_pkg::word_t'($signed({k, 4'b0000}));
    endfunction

    function automatic ldu_pkg::word_t addsat(input ldu_pkg::word_t a,
                                              input ldu_pkg::word_t b,
                                              input logic sub);
        logic signed [ldu_pkg::WORD_W:0] s;
        s = sub ? ((ldu_pkg::WORD_W+1)'(a) - (ldu_pkg::WORD_W+1)'(b))
                : ((ldu_pkg::WORD_W+1)'(a) + (ldu_pkg::WORD_W+1)'(b));
        if (s > (ldu_pkg::WORD_W+1)'(ldu_pkg::LIM))
        begin
            return ldu_pkg::LIM;
        end
        if (s < -(ldu_pkg::WORD_W+1)'(ldu_pkg::LIM))
        begin
            return -ldu_pkg::LIM;
        end
        return s[ldu_pkg::WORD_W-1:0];
    endfunction

    function automatic logic signed [ldu_pkg::COORD_W-1:0] sat32(input ldu_pkg::word_t v);
        if (v > ldu_pkg::word_t'(32'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < ldu_pkg::word_t'(-33'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return v[ldu_pkg::COORD_W-1:0];
    endfunction

    function automatic ldu_pkg::word_t operand(input ldu_pkg::src_t s, input ldu_pkg::word_t rd);
        case (s)
            ldu_pkg::S_ZERO: return '0;
            ldu_pkg::S_ONE:  return ldu_pkg::ONE;
            ldu_pkg::S_TX:   return ldu_pkg::word_t'(tx_reg);
            ldu_pkg::S_TY:   return ldu_pkg::word_t'(ty_reg);
            ldu_pkg::S_K1:   return coef(k1_reg);
            ldu_pkg::S_K2:   return coef(k2_reg);
            ldu_pkg::S_K3:   return coef(k3_reg);
            ldu_pkg::S_P1:   return coef(p1_reg);
            ldu_pkg::S_P2:   return coef(p2_reg);
            default:         return rd;
        endcase
    endfunction

    ldu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .p     (mul_p)
    );

    ldu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (opa),
        .d     (opb),
        .done  (div_done),
        .q     (div_q)
    );

    assign instr = ldu_pkg::prog(pc_reg);

    always_comb
    begin
        opa = operand(instr.a, rda_reg);
        opb = operand(instr.b, rdb_reg);
    end

    assign mag_a = opa[ldu_pkg::WORD_W-1] ? -opa : opa;
    assign mag_b = opb[ldu_pkg::WORD_W-1] ? -opb : opb;

    always_comb
    begin
        if (state_reg == ldu_pkg::S_ORD || state_reg == ldu_pkg::S_OWR)
        begin
            ra = ldu_pkg::R_EX[ldu_pkg::RF_AW-1:0];
            rb = ldu_pkg::R_EY[ldu_pkg::RF_AW-1:0];
        end
        else
        begin
            ra = instr.a[ldu_pkg::RF_AW-1:0];
            rb = instr.b[ldu_pkg::RF_AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[instr.dst[ldu_pkg::RF_AW-1:0]] <= rf_wdata;
        end
        rda_reg <= rf_mem[ra];
        rdb_reg <= rf_mem[rb];
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        iter_next  = iter_reg;
        conv_next  = conv_reg;
        sing_next  = sing_reg;
        rf_we      = 1'b0;
        rf_wdata   = '0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ldu_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    pc_next    = '0;
                    iter_next  = '0;
                    state_next = ldu_pkg::S_FETCH;
                end
            end
            ldu_pkg::S_FETCH:
            begin
                state_next = ldu_pkg::S_EXEC;
            end
            ldu_pkg::S_EXEC:
            begin
                state_next = ldu_pkg::S_FETCH;
                pc_next    = pc_reg + 1'b1;
                case (instr.op)
                    ldu_pkg::U_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = addsat(opa, opb, 1'b0);
                    end
                    ldu_pkg::U_SUB:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = addsat(opa, opb, 1'b1);
                    end
                    ldu_pkg::U_MUL:
                    begin
                        mul_start  = 1'b1;
                        pc_next    = pc_reg;
                        state_next = ldu_pkg::S_WAIT;
                    end
                    ldu_pkg::U_DIV:
                    begin
                        div_start  = 1'b1;
                        pc_next    = pc_reg;
                        state_next = ldu_pkg::S_WAIT;
                    end
                    ldu_pkg::U_SPLIT:
                    begin
                        if (op_reg)
                        begin
                            pc_next = ldu_pkg::L_RESID;
                        end
                    end
                    ldu_pkg::U_FIN:
                    begin
                        conv_next  = 1'b1;
                        sing_next  = 1'b0;
                        state_next = ldu_pkg::S_ORD;
                    end
                    ldu_pkg::U_CONV:
                    begin
                        if (mag_a < ldu_pkg::WORD_W'(tol_reg) &&
                            mag_b < ldu_pkg::WORD_W'(tol_reg))
                        begin
                            conv_next  = 1'b1;
                            sing_next  = 1'b0;
                            state_next = ldu_pkg::S_ORD;
                        end
                    end
                    ldu_pkg::U_SING:
                    begin
                        if (opa == '0)
                        begin
                            conv_next  = 1'b0;
                            sing_next  = 1'b1;
                            state_next = ldu_pkg::S_ORD;
                        end
                    end
                    ldu_pkg::U_LOOP:
                    begin
                        if (iter_reg == ldu_pkg::ITER_W'(ldu_pkg::MAX_ITERATIONS - 1))
                        begin
                            conv_next  = 1'b0;
                            sing_next  = 1'b0;
                            pc_next    = pc_reg;
                            state_next = ldu_pkg::S_ORD;
                        end
                        else
                        begin
                            iter_next = iter_reg + 1'b1;
                            pc_next   = ldu_pkg::L_LOOP;
                        end
                    end
                    default:
                    begin
                        state_next = ldu_pkg::S_IDLE;
                    end
                endcase
            end
            ldu_pkg::S_WAIT:
            begin
                if (instr.op == ldu_pkg::U_MUL && mul_done)
                begin
                    rf_we      = 1'b1;
                    rf_wdata   = mul_p;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ldu_pkg::S_FETCH;
                end
                else if (instr.op == ldu_pkg::U_DIV && div_done)
                begin
                    rf_we      = 1'b1;
                    rf_wdata   = div_q;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ldu_pkg::S_FETCH;
                end
            end
            ldu_pkg::S_ORD:
            begin
                state_next = ldu_pkg::S_OWR;
            end
            ldu_pkg::S_OWR:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ldu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ldu_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldu_pkg::S_IDLE;
            pc_reg        <= '0;
            iter_reg      <= '0;
            conv_reg      <= 1'b0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            iter_reg      <= iter_next;
            conv_reg      <= conv_next;
            sing_reg      <= sing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg  <= '0;
            k2_reg  <= '0;
            k3_reg  <= '0;
            p1_reg  <= '0;
            p2_reg  <= '0;
            tol_reg <= ldu_pkg::TOL_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                ldu_pkg::CFG_K1:  k1_reg  <= cfg_ch.data;
                ldu_pkg::CFG_K2:  k2_reg  <= cfg_ch.data;
                ldu_pkg::CFG_K3:  k3_reg  <= cfg_ch.data;
                ldu_pkg::CFG_P1:  p1_reg  <= cfg_ch.data;
                ldu_pkg::CFG_P2:  p2_reg  <= cfg_ch.data;
                ldu_pkg::CFG_TOL: tol_reg <= cfg_ch.data[ldu_pkg::TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ldu_pkg::S_IDLE && in_ch.valid)
        begin
            op_reg <= in_ch.op;
            tx_reg <= in_ch.in_x;
            ty_reg <= in_ch.in_y;
        end
        if (out_load)
        begin
            out_x_reg    <= sat32(rda_reg);
            out_y_reg    <= sat32(rdb_reg);
            out_conv_reg <= conv_reg;
            out_sing_reg <= sing_reg;
        end
    end

    assign in_ch.ready      = (state_reg == ldu_pkg::S_IDLE);
    assign cfg_ch.ready     = 1'b1;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_x     = out_x_reg;
    assign out_ch.out_y     = out_y_reg;
    assign out_ch.converged = out_conv_reg;
    assign out_ch.singular  = out_sing_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_conv_reg && out_sing_reg))
        else $error("Result beat carries both converged and singular.");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (opb != '0))
        else $error("Divider started with a zero determinant.");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ldu_pkg::S_IDLE) |-> (pc_reg < ldu_pkg::PC_W'(ldu_pkg::PROG_LEN)))
        else $error("Program counter ran past the microprogram.");

    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || div_done) |-> (state_reg == ldu_pkg::S_WAIT))
        else $error("Arithmetic unit finished while the sequencer was not waiting.");

endmodule
